@@ hdl/mdm_pkg.sv @@
// ----------------------------------------------------------------------------
// MDIO master package
// Shared transaction types, command and register codes for the MDIO master.
// ----------------------------------------------------------------------------
`default_nettype none

package mdm_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_WR_DATA  = 3'd1;
  localparam logic [2:0] CMD_WR_CMD   = 3'd2;
  localparam logic [2:0] CMD_RD_WSTAT = 3'd3;
  localparam logic [2:0] CMD_RD_RDATA = 3'd4;

  localparam logic [1:0] C22_OP_READ   = 2'd1;
  localparam logic [1:0] C45_OP_RD_INC = 2'd2;
  localparam logic [1:0] C45_OP_READ   = 2'd3;
  localparam logic [1:0] C45_OP_WRITE  = 2'd1;

  localparam logic [1:0] C22_OPC_READ  = 2'b10;
  localparam logic [1:0] C22_OPC_WRITE = 2'b01;
  localparam logic [1:0] ST_C22        = 2'b01;
  localparam logic [1:0] ST_C45        = 2'b00;
  localparam logic [1:0] TA_WRITE      = 2'b10;
  localparam logic [1:0] TA_READ       = 2'b00;

  localparam logic [2:0] REG_CLK_HALF  = 3'd0;
  localparam logic [2:0] REG_SAMPLE    = 3'd1;
  localparam logic [2:0] REG_PREAMBLE  = 3'd2;
  localparam logic [2:0] REG_CLAUSE45  = 3'd3;
  localparam logic [2:0] REG_ENABLE    = 3'd4;

  localparam int unsigned PADDR_W = 5;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_WR_DATA,
    KIND_WR_CMD,
    KIND_RD_WSTAT,
    KIND_RD_RDATA
  } mdm_kind_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  port_addr;
    logic [4:0]  reg_addr;
    logic [1:0]  phy_op;
    logic [15:0] data_word;
    logic        mdio_in;
  } mdm_in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        data_valid;
    logic        pending;
    logic        mdc;
    logic        mdio_out;
    logic        mdio_drive;
  } mdm_out_t;

  typedef struct packed {
    mdm_kind_e   kind;
    logic [4:0]  port_addr;
    logic [4:0]  reg_addr;
    logic [1:0]  phy_op;
    logic [15:0] data_word;
    logic        mdio_in;
  } mdm_entry_t;

  typedef struct packed {
    logic [7:0] clk_half_period;
    logic [3:0] sample_delay;
    logic       preamble_enable;
    logic       clause45_mode;
    logic       block_enable;
  } mdm_cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } mdm_qstat_t;

endpackage

`default_nettype wire

@@ hdl/mdm_front.sv @@
// ----------------------------------------------------------------------------
// MDIO master front end
// Accepts input transactions and classifies the command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mdm_front
  import mdm_pkg::*;
(
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire mdm_in_t    in_data_i,
  output      logic       push_o,
  output      mdm_entry_t push_entry_o,
  input  wire logic       q_full_i
);

  mdm_kind_e kind;

  always_comb begin
    unique case (in_data_i.cmd)
      CMD_WR_DATA:  kind = KIND_WR_DATA;
      CMD_WR_CMD:   kind = KIND_WR_CMD;
      CMD_RD_WSTAT: kind = KIND_RD_WSTAT;
      CMD_RD_RDATA: kind = KIND_RD_RDATA;
      default:      kind = KIND_TICK;
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign push_entry_o = '{
    kind:      kind,
    port_addr: in_data_i.port_addr,
    reg_addr:  in_data_i.reg_addr,
    phy_op:    in_data_i.phy_op,
    data_word: in_data_i.data_word,
    mdio_in:   in_data_i.mdio_in
  };

endmodule

`default_nettype wire

@@ hdl/mdm_queue.sv @@
// ----------------------------------------------------------------------------
// MDIO master command queue
// Small FIFO between the front end and the frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mdm_queue
  import mdm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire mdm_entry_t push_entry_i,
  input  wire logic       pop_i,
  output      mdm_entry_t pop_entry_o,
  output      mdm_qstat_t stat_o
);

  mdm_entry_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));

endmodule

`default_nettype wire

@@ hdl/mdm_back.sv @@
// ----------------------------------------------------------------------------
// MDIO master frame engine
// Executes one queued transaction per cycle when not stalled: register access,
// frame start and the MDC/MDIO serializer, with a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mdm_back
  import mdm_pkg::*;
#(
  parameter int unsigned PREAMBLE_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire mdm_cfg_t   cfg_i,
  input  wire mdm_entry_t entry_i,
  input  wire logic       q_empty_i,
  output      logic       pop_o,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      mdm_out_t   out_data_o
);

  localparam int unsigned PW = $clog2(PREAMBLE_BITS + 1);

  logic [31:0]   fs_q, fs_d;
  logic [5:0]    bit_q, bit_d;
  logic [PW-1:0] pre_q, pre_d;
  logic [7:0]    tick_q, tick_d;
  logic          clk_q, clk_d;
  logic          busy_q, busy_d;
  logic          rop_q, rop_d;
  logic [15:0]   wdata_q, wdata_d;
  logic [15:0]   rdata_q, rdata_d;
  logic          rvalid_q, rvalid_d;
  logic          wvalid_q, wvalid_d;
  logic          out_valid_q;
  mdm_out_t      out_q, res;

  assign pop_o = !q_empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    logic        started;
    logic [7:0]  hp;
    logic [7:0]  sp;
    logic [8:0]  t1;
    logic [1:0]  st;
    logic [1:0]  opc;
    logic [1:0]  ta;
    logic [15:0] dat;
    logic        drv;
    logic        lvl;

    fs_d     = fs_q;
    bit_d    = bit_q;
    pre_d    = pre_q;
    tick_d   = tick_q;
    clk_d    = clk_q;
    busy_d   = busy_q;
    rop_d    = rop_q;
    wdata_d  = wdata_q;
    rdata_d  = rdata_q;
    rvalid_d = rvalid_q;
    wvalid_d = wvalid_q;
    started  = 1'b0;
    res      = '0;
    st       = ST_C22;
    opc      = C22_OPC_WRITE;
    ta       = TA_WRITE;
    dat      = '0;

    if (!cfg_i.block_enable) begin
      busy_d = 1'b0;
      clk_d  = 1'b1;
      tick_d = '0;
      bit_d  = '0;
      pre_d  = '0;
    end

    unique case (entry_i.kind)
      KIND_RD_WSTAT: begin
        res.read_data  = wdata_d;
        res.data_valid = wvalid_d;
        res.pending    = busy_d && !rop_d;
      end
      KIND_RD_RDATA: begin
        res.read_data  = rdata_d;
        res.data_valid = rvalid_d;
        res.pending    = busy_d && rop_d;
      end
      KIND_WR_DATA: begin
        wdata_d  = entry_i.data_word;
        wvalid_d = 1'b0;
      end
      KIND_WR_CMD: begin
        if (cfg_i.block_enable && !busy_d) begin
          if (cfg_i.clause45_mode) begin
            st    = ST_C45;
            opc   = entry_i.phy_op;
            rop_d = (opc == C45_OP_READ) || (opc == C45_OP_RD_INC);
          end else begin
            st    = ST_C22;
            rop_d = ({1'b0, entry_i.phy_op[0]} == C22_OP_READ);
            opc   = rop_d ? C22_OPC_READ : C22_OPC_WRITE;
          end
          if (rop_d) begin
            ta       = TA_READ;
            dat      = '0;
            rvalid_d = 1'b0;
          end else begin
            ta       = TA_WRITE;
            dat      = wdata_d;
            wvalid_d = 1'b0;
          end
          fs_d    = {st, opc, entry_i.port_addr, entry_i.reg_addr, ta, dat};
          bit_d   = '0;
          pre_d   = cfg_i.preamble_enable ? PW'(PREAMBLE_BITS) : '0;
          tick_d  = '0;
          clk_d   = 1'b0;
          busy_d  = 1'b1;
          started = 1'b1;
        end
      end
      KIND_TICK: ;
      default: ;
    endcase

    hp = (cfg_i.clk_half_period == '0) ? 8'd1 : cfg_i.clk_half_period;
    sp = ({4'b0, cfg_i.sample_delay} < hp) ? {4'b0, cfg_i.sample_delay} : hp - 8'd1;
    t1 = {1'b0, tick_d} + 9'd1;

    if (!started) begin
      if (!busy_d) begin
        clk_d  = 1'b1;
        tick_d = '0;
      end else begin
        if (clk_d && pre_d == '0 && rop_d && bit_d >= 6'd16 && tick_d == sp) begin
          fs_d[0] = entry_i.mdio_in;
        end
        if (t1 < {1'b0, hp}) begin
          tick_d = t1[7:0];
        end else begin
          tick_d = '0;
          if (!clk_d) begin
            clk_d = 1'b1;
          end else begin
            if (pre_d != '0) begin
              pre_d = pre_d - PW'(1);
            end else begin
              fs_d  = {fs_d[30:0], 1'b0};
              bit_d = bit_d + 6'd1;
            end
            if (pre_d == '0 && bit_d >= 6'd32) begin
              if (rop_d) begin
                rdata_d  = fs_d[16:1];
                rvalid_d = 1'b1;
              end else begin
                wvalid_d = 1'b1;
              end
              busy_d = 1'b0;
              clk_d  = 1'b1;
              tick_d = '0;
              bit_d  = '0;
              pre_d  = '0;
            end else begin
              clk_d = 1'b0;
            end
          end
        end
      end
    end

    if (!busy_d) begin
      drv = 1'b0;
      lvl = 1'b0;
    end else if (pre_d != '0) begin
      drv = 1'b1;
      lvl = 1'b1;
    end else begin
      drv = !(rop_d && bit_d >= 6'd14);
      lvl = drv && fs_d[31];
    end

    res.mdc        = clk_d;
    res.mdio_out   = lvl;
    res.mdio_drive = drv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q        <= '0;
      bit_q       <= '0;
      pre_q       <= '0;
      tick_q      <= '0;
      clk_q       <= 1'b1;
      busy_q      <= 1'b0;
      rop_q       <= 1'b0;
      wdata_q     <= '0;
      rdata_q     <= '0;
      rvalid_q    <= 1'b0;
      wvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        fs_q     <= fs_d;
        bit_q    <= bit_d;
        pre_q    <= pre_d;
        tick_q   <= tick_d;
        clk_q    <= clk_d;
        busy_q   <= busy_d;
        rop_q    <= rop_d;
        wdata_q  <= wdata_d;
        rdata_q  <= rdata_d;
        rvalid_q <= rvalid_d;
        wvalid_q <= wvalid_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hdl/mdio_master_controller.sv @@
// ----------------------------------------------------------------------------
// MDIO master controller
// Clause 22 / clause 45 management master behind an APB register set.
// ----------------------------------------------------------------------------
// Each input transaction is one core clock of the MDIO engine: a tick, a
// write of the write-data register, a frame command, or a status read. Every
// accepted transaction yields exactly one result transaction carrying the
// register read value (zero unless a read), and the MDC/MDIO pin levels.
// The front end classifies and queues a transaction (two entries); the frame
// engine takes one entry per cycle unless the receiver stalls, and registers
// its result. Throughput: one transaction per clock, unless stalled. A
// transaction is written into the queue, and the engine's result register
// then holds its result. When the receiver stalls, the result is held, the
// engine stops and the queue fills; in_ready_o drops once both entries are
// taken. Reset clears the engine: MDC idles high, MDIO released, flags clear,
// and the configuration returns to half period 32, sample delay 2, no
// preamble, clause 22, enabled. The user writes configuration over APB only
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module mdio_master_controller
  import mdm_pkg::*;
#(
  parameter int unsigned PREAMBLE_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire mdm_in_t            in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      mdm_out_t           out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  mdm_cfg_t   cfg_q;
  logic       push;
  mdm_entry_t push_entry;
  mdm_entry_t pop_entry;
  logic       q_pop;
  mdm_qstat_t q_stat;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clk_half_period <= 8'd32;
      cfg_q.sample_delay    <= 4'd2;
      cfg_q.preamble_enable <= 1'b0;
      cfg_q.clause45_mode   <= 1'b0;
      cfg_q.block_enable    <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_CLK_HALF: cfg_q.clk_half_period <= pwdata[7:0];
        REG_SAMPLE:   cfg_q.sample_delay    <= pwdata[3:0];
        REG_PREAMBLE: cfg_q.preamble_enable <= pwdata[0];
        REG_CLAUSE45: cfg_q.clause45_mode   <= pwdata[0];
        REG_ENABLE:   cfg_q.block_enable    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CLK_HALF: prdata = {24'd0, cfg_q.clk_half_period};
      REG_SAMPLE:   prdata = {28'd0, cfg_q.sample_delay};
      REG_PREAMBLE: prdata = {31'd0, cfg_q.preamble_enable};
      REG_CLAUSE45: prdata = {31'd0, cfg_q.clause45_mode};
      REG_ENABLE:   prdata = {31'd0, cfg_q.block_enable};
      default:      prdata = '0;
    endcase
  end

  mdm_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .q_full_i     (q_stat.full)
  );

  mdm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (q_pop),
    .pop_entry_o  (pop_entry),
    .stat_o       (q_stat)
  );

  mdm_back #(
    .PREAMBLE_BITS (PREAMBLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .entry_i     (pop_entry),
    .q_empty_i   (q_stat.empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_released_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.mdio_drive |-> !out_data_o.mdio_out)
    else $error("MDIO level driven while released");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !q_stat.empty)
    else $error("accepted transaction missing from queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("engine popped an empty queue");

  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o)
    else $error("executed transaction produced no result");

endmodule

`default_nettype wire
